/* sv/btb_pkg.sv */
// ----------------------------------------------------------------------------
// btb_pkg
// Types and constants shared by the branch target buffer predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package btb_pkg;

  localparam int unsigned MaxEntriesLog2 = 5;
  localparam int unsigned MaxHistory     = 8;
  localparam int unsigned MaxTag         = 30;
  localparam int unsigned SlotW          = MaxEntriesLog2;
  localparam int unsigned CntAddrW       = SlotW + MaxHistory;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 5;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENTRIES_LOG2   = 3'd0,
    CFG_HISTORY_BITS   = 3'd1,
    CFG_TAG_BITS       = 3'd2,
    CFG_COUNTER_INIT   = 3'd3,
    CFG_GLOBAL_HISTORY = 3'd4,
    CFG_GLOBAL_TABLE   = 3'd5,
    CFG_SHARE_MODE     = 3'd6,
    CFG_UNUSED         = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    SHARE_NONE = 2'd0,
    SHARE_PC2  = 2'd1,
    SHARE_PC16 = 2'd2,
    SHARE_RSVD = 2'd3
  } share_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_WIPE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] pc;
    logic [31:0] target_pc;
    logic        taken;
    logic [31:0] predicted_dst;
  } in_item_t;

  typedef struct packed {
    logic        predict_taken;
    logic [31:0] predicted_target;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
  } out_item_t;

  typedef struct packed {
    logic [MaxTag-1:0]     tag;
    logic [31:0]           target;
    logic [MaxHistory-1:0] hist;
  } entry_t;

endpackage

`default_nettype wire

/* sv/btb_two_level_branch_predictor.sv */
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor
// Direct-mapped branch target buffer with 2-bit counters indexed by history.
// ----------------------------------------------------------------------------
//  channel | ports                            | role
//  in      | in_valid, in_stall, in_data      | predict / update transaction
//  out     | out_valid, out_stall, out_data   | one result per transaction
//  cfg     | cfg_we, cfg_index, cfg_wdata     | register write, no read-back
//
//  One transaction at a time, in steps: entry read, counter read, result;
//  the entry and counter memories are read through registers.
//  An update that replaces an entry with per-entry tables first refills
//  that entry's counter block.
//  After reset and after every config write to a used index, the
//  8192-entry counter memory is swept; inputs stall meanwhile.
//  A full output register holds the block in its last cycle until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module btb_two_level_branch_predictor (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire btb_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output btb_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [btb_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [btb_pkg::CfgDataW-1:0]      cfg_wdata
);
  import btb_pkg::*;

  localparam int unsigned NumSlots = 1 << SlotW;
  localparam int unsigned CntDepth = 1 << CntAddrW;

  // config registers
  logic [2:0] entries_log2_r;
  logic [3:0] history_bits_r;
  logic [4:0] tag_bits_r;
  logic [1:0] counter_init_r;
  logic       global_history_r;
  logic       global_table_r;
  logic [1:0] share_mode_r;

  state_t state_r, state_nxt;

  // memories
  entry_t     ent_mem [NumSlots];
  logic [1:0] cnt_mem [CntDepth];
  entry_t     ent_rd_r;
  logic [1:0] cnt_rd_r;

  logic [NumSlots-1:0]   valid_r;
  logic [MaxHistory-1:0] ghist_r;
  logic [31:0]           branches_r, flushes_r;
  in_item_t              item_r;
  logic [SlotW-1:0]      slot_r;
  logic [MaxTag-1:0]     tag_r;
  logic                  hit_r;
  logic [MaxHistory-1:0] hist_r;
  logic [CntAddrW-1:0]   pos_r;
  logic                  use_init_r;
  logic [CntAddrW-1:0]   sweep_r;
  out_item_t             out_r;
  logic                  out_valid_r;

  // derived configuration
  logic [2:0]            el_sat;
  logic [SlotW-1:0]      slot_mask;
  logic [4:0]            tb_sat;
  logic [MaxTag-1:0]     tag_mask;
  logic [3:0]            hl_sat;
  logic [MaxHistory-1:0] hmask;

  always_comb begin
    el_sat    = (entries_log2_r > 3'(MaxEntriesLog2)) ? 3'(MaxEntriesLog2) : entries_log2_r;
    slot_mask = SlotW'((32'd1 << el_sat) - 32'd1);
    tb_sat    = (tag_bits_r > 5'(MaxTag)) ? 5'(MaxTag) : tag_bits_r;
    tag_mask  = MaxTag'((32'd1 << tb_sat) - 32'd1);
    hl_sat    = (history_bits_r > 4'(MaxHistory)) ? 4'(MaxHistory) : history_bits_r;
    hmask     = MaxHistory'((32'd1 << hl_sat) - 32'd1);
  end

  logic in_fire, cfg_fire, done_fire;
  logic [SlotW-1:0] in_slot;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_we && (cfg_index != CFG_UNUSED);
  assign done_fire = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign in_slot   = in_data.pc[SlotW+1:2] & slot_mask;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // lookup stage: hit, history and counter position
  logic                  lk_hit, lk_reset_hist, lk_wipe;
  logic [MaxHistory-1:0] lk_hist, lk_mix;
  logic [CntAddrW-1:0]   lk_pos;

  always_comb begin
    lk_hit        = valid_r[slot_r] && (ent_rd_r.tag == tag_r);
    lk_reset_hist = (item_r.cmd == CMD_UPDATE) && !lk_hit;
    if (global_history_r) begin
      lk_hist = ghist_r;
    end else if (lk_reset_hist) begin
      lk_hist = '0;
    end else begin
      lk_hist = ent_rd_r.hist;
    end
    case (share_t'(share_mode_r))
      SHARE_PC2:  lk_mix = item_r.pc[MaxHistory+1:2];
      SHARE_PC16: lk_mix = item_r.pc[MaxHistory+15:16];
      default:    lk_mix = '0;
    endcase
    lk_pos  = {(global_table_r ? SlotW'(0) : slot_r), (lk_hist ^ lk_mix) & hmask};
    lk_wipe = lk_reset_hist && !global_table_r;
  end

  // finishing stage: counter training and result
  logic [1:0]            cnt_cur, cnt_new;
  logic [MaxHistory-1:0] hist_new;
  logic [31:0]           fall, actual_dst, br_new, fl_new;

  always_comb begin
    cnt_cur = use_init_r ? counter_init_r : cnt_rd_r;
    if (item_r.taken) begin
      cnt_new = (cnt_cur == 2'd3) ? cnt_cur : cnt_cur + 2'd1;
    end else begin
      cnt_new = (cnt_cur == 2'd0) ? cnt_cur : cnt_cur - 2'd1;
    end
    hist_new   = {hist_r[MaxHistory-2:0], item_r.taken} & hmask;
    fall       = item_r.pc + 32'd4;
    actual_dst = item_r.taken ? item_r.target_pc : fall;
    br_new     = branches_r + 32'd1;
    fl_new     = flushes_r + ((item_r.predicted_dst != actual_dst) ? 32'd1 : 32'd0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: if (sweep_r == CntAddrW'(CntDepth - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (in_fire) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = lk_wipe ? ST_WIPE : ST_DONE;
      ST_WIPE: if (sweep_r[MaxHistory-1:0] == '1) state_nxt = ST_DONE;
      ST_DONE: if (done_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_INIT;
    endcase
    if (cfg_fire) state_nxt = ST_INIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config registers, sweep counter, control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_log2_r   <= 3'd0;
      history_bits_r   <= 4'd1;
      tag_bits_r       <= 5'd0;
      counter_init_r   <= 2'd1;
      global_history_r <= 1'b0;
      global_table_r   <= 1'b0;
      share_mode_r     <= 2'd0;
      sweep_r          <= '0;
      valid_r          <= '0;
      ghist_r          <= '0;
      branches_r       <= '0;
      flushes_r        <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_INIT || state_r == ST_WIPE) sweep_r <= sweep_r + CntAddrW'(1);
      if (state_r == ST_LOOK) sweep_r <= '0;
      if (done_fire) begin
        out_valid_r <= 1'b1;
        if (item_r.cmd == CMD_UPDATE) begin
          branches_r <= br_new;
          flushes_r  <= fl_new;
          if (!hit_r) valid_r[slot_r] <= 1'b1;
          if (global_history_r) ghist_r <= hist_new;
        end
      end
      if (cfg_fire) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENTRIES_LOG2:   entries_log2_r   <= cfg_wdata[2:0];
          CFG_HISTORY_BITS:   history_bits_r   <= cfg_wdata[3:0];
          CFG_TAG_BITS:       tag_bits_r       <= cfg_wdata[4:0];
          CFG_COUNTER_INIT:   counter_init_r   <= cfg_wdata[1:0];
          CFG_GLOBAL_HISTORY: global_history_r <= cfg_wdata[0];
          CFG_GLOBAL_TABLE:   global_table_r   <= cfg_wdata[0];
          CFG_SHARE_MODE:     share_mode_r     <= cfg_wdata[1:0];
          default:            ;
        endcase
        sweep_r    <= '0;
        valid_r    <= '0;
        ghist_r    <= '0;
        branches_r <= '0;
        flushes_r  <= '0;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
      slot_r <= in_slot;
      tag_r  <= in_data.pc[MaxTag+1:2] & tag_mask;
    end
    if (state_r == ST_LOOK) begin
      hit_r      <= lk_hit;
      hist_r     <= lk_hist;
      pos_r      <= lk_pos;
      use_init_r <= lk_wipe;
    end
    if (done_fire) begin
      if (item_r.cmd == CMD_UPDATE) begin
        out_r.predict_taken    <= 1'b0;
        out_r.predicted_target <= '0;
        out_r.branch_count     <= br_new;
        out_r.flush_count      <= fl_new;
      end else begin
        out_r.predict_taken    <= hit_r && cnt_cur[1];
        out_r.predicted_target <= (hit_r && cnt_cur[1]) ? ent_rd_r.target : fall;
        out_r.branch_count     <= branches_r;
        out_r.flush_count      <= flushes_r;
      end
    end
  end

  // entry memory: read on accept, written back when an update finishes
  always_ff @(posedge clk) begin
    if (in_fire) ent_rd_r <= ent_mem[in_slot];
    if (done_fire && item_r.cmd == CMD_UPDATE) begin
      ent_mem[slot_r] <= '{
        tag:    hit_r ? ent_rd_r.tag : tag_r,
        target: hit_r ? ent_rd_r.target : item_r.target_pc,
        hist:   global_history_r ? ent_rd_r.hist : hist_new
      };
    end
  end

  // counter memory: sweeps, lookup read, trained write
  logic                cnt_we;
  logic [CntAddrW-1:0] cnt_waddr;
  logic [1:0]          cnt_wdata;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = pos_r;
    cnt_wdata = cnt_new;
    case (state_r)
      ST_INIT: begin
        cnt_we    = 1'b1;
        cnt_waddr = sweep_r;
        cnt_wdata = counter_init_r;
      end
      ST_WIPE: begin
        cnt_we    = 1'b1;
        cnt_waddr = {slot_r, sweep_r[MaxHistory-1:0]};
        cnt_wdata = counter_init_r;
      end
      ST_DONE: cnt_we = done_fire && (item_r.cmd == CMD_UPDATE);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK) cnt_rd_r <= cnt_mem[lk_pos];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
  end

endmodule

`default_nettype wire
